// ===== rtl/core/cosine_similarity_engine_macros.svh =====
// ----------------------------------------------------------------------------
// Cosine similarity engine assertion macros
// Shared property wrappers for the checker attached to the engine ports.
// ----------------------------------------------------------------------------
`ifndef COSINE_SIMILARITY_ENGINE_MACROS_SVH
`define COSINE_SIMILARITY_ENGINE_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define CSE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define CSE_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/core/cse_pkg.sv =====
// ----------------------------------------------------------------------------
// Cosine similarity engine package
// Widths, step counts, sequencer states and helpers shared by the engine.
// ----------------------------------------------------------------------------
package cse_pkg;

   localparam int MAX_DIM_DEF = 1024;

   localparam int VAL_W   = 16;           // Q3.12 element
   localparam int SIM_W   = 16;           // Q1.15 result
   localparam int DOT_W   = 42;
   localparam int NORM_W  = 41;
   localparam int MULT_W  = 17;           // shared signed multiplier operand
   localparam int PROD_W  = 2 * MULT_W;
   localparam int LIMB_W  = 16;
   localparam int WORK_W  = 2 * NORM_W;   // norm product / shift register
   localparam int ROOT_W  = 42;
   localparam int REM_W   = 44;
   localparam int QUO_W   = 17;
   localparam int ITER_W  = 6;
   localparam int SHAMT_W = 7;

   localparam int ROOT_STEPS = WORK_W / 2;            // two radicand bits a step
   localparam int DIV_STEPS  = DOT_W + 15;            // dividend is dot << 15
   localparam int DIV_PAD    = WORK_W - DIV_STEPS;

   localparam logic [ITER_W-1:0] ROOT_LAST = ITER_W'(ROOT_STEPS - 1);
   localparam logic [ITER_W-1:0] DIV_LAST  = ITER_W'(DIV_STEPS - 1);

   // multiply-accumulate steps of one element pair
   localparam logic [1:0] MAC_DOT    = 2'd0;
   localparam logic [1:0] MAC_FIRST  = 2'd1;
   localparam logic [1:0] MAC_SECOND = 2'd2;
   // highest limb index of a norm sum
   localparam logic [1:0] LIMB_LAST  = 2'd2;

   localparam logic [SIM_W-1:0] SIM_MAX = 16'h7FFF;
   localparam logic [SIM_W-1:0] SIM_MIN = 16'h8000;
   localparam logic [QUO_W-1:0] QUO_POS_MAX = 17'd32767;
   localparam logic [QUO_W-1:0] QUO_NEG_MAX = 17'd32768;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_MUL  = 7'b0000010,
      ST_ADD  = 7'b0000100,
      ST_NORM = 7'b0001000,
      ST_ROOT = 7'b0010000,
      ST_DIV  = 7'b0100000,
      ST_DONE = 7'b1000000
   } state_type;

   // 16-bit limb of a norm sum, index 0 is least significant
   function automatic logic [LIMB_W-1:0] norm_limb(input logic [NORM_W-1:0] x,
                                                   input logic [1:0] idx);
      logic [3*LIMB_W-1:0] w;
      w = {(3*LIMB_W-NORM_W)'(0), x};
      case (idx)
         2'd0:    norm_limb = w[LIMB_W-1:0];
         2'd1:    norm_limb = w[2*LIMB_W-1:LIMB_W];
         2'd2:    norm_limb = w[3*LIMB_W-1:2*LIMB_W];
         default: norm_limb = '0;
      endcase
   endfunction

endpackage

// ===== rtl/core/cosine_similarity_engine.sv =====
// A pair without last, within full length, holds req_ready low through three
// rounds on the one 17x17 multiplier; a new pair is taken only after them.
// A last pair adds a zero-norm check, the norm product (9 partial products), a
// 41-step square root and a 57-step divide on one shared subtractor before
// rsp_valid rises; a zero norm skips those three, and a stall on rsp_ready delays it.
// Reset (synchronous, active high) clears all sums, counters and rsp_valid.
// ----------------------------------------------------------------------------
// Cosine similarity engine
// Accumulates dot product and squared norms per element pair and returns the
// saturated Q1.15 cosine similarity on the pair marked last.
// ----------------------------------------------------------------------------
module cosine_similarity_engine #(
   parameter int MAX_DIM = cse_pkg::MAX_DIM_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [cse_pkg::VAL_W-1:0] req_first_value,
   input  logic signed [cse_pkg::VAL_W-1:0] req_second_value,
   input  logic                           req_last,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [cse_pkg::SIM_W-1:0] rsp_similarity,
   output logic                           rsp_zero_norm,
   output logic                           rsp_too_long
);

   localparam int CNT_W = $clog2(MAX_DIM + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_DIM);

   cse_pkg::state_type state_ff, state_in;

   logic [cse_pkg::DOT_W-1:0]   dot_ff, dot_in;
   logic [cse_pkg::NORM_W-1:0]  norm1_ff, norm1_in;
   logic [cse_pkg::NORM_W-1:0]  norm2_ff, norm2_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic                        ovf_ff, ovf_in;

   logic signed [cse_pkg::VAL_W-1:0] a_ff, a_in;
   logic signed [cse_pkg::VAL_W-1:0] b_ff, b_in;
   logic                        last_ff, last_in;
   logic                        phase_ff, phase_in;   // 1 while forming the norm product
   logic [1:0]                  ia_ff, ia_in;
   logic [1:0]                  ib_ff, ib_in;
   logic signed [cse_pkg::PROD_W-1:0] prod_ff, prod_in;

   logic [cse_pkg::WORK_W-1:0]  work_ff, work_in;
   logic [cse_pkg::REM_W-1:0]   rem_ff, rem_in;
   logic [cse_pkg::ROOT_W-1:0]  root_ff, root_in;
   logic [cse_pkg::QUO_W-1:0]   quo_ff, quo_in;
   logic                        big_ff, big_in;
   logic                        neg_ff, neg_in;
   logic                        zero_ff, zero_in;
   logic [cse_pkg::ITER_W-1:0]  iter_ff, iter_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [cse_pkg::SIM_W-1:0]   sim_ff, sim_in;
   logic                        zflag_ff, zflag_in;
   logic                        long_ff, long_in;

   // shared multiplier
   logic signed [cse_pkg::MULT_W-1:0] mul_a, mul_b;
   logic signed [cse_pkg::PROD_W-1:0] mul_p;

   // shared subtract / compare
   logic [cse_pkg::REM_W-1:0]   sub_a, sub_b, sub_d;
   logic                        sub_ge;

   logic [cse_pkg::DOT_W-1:0]   dot_mag;
   logic [cse_pkg::WORK_W-1:0]  partial;
   logic [cse_pkg::SHAMT_W-1:0] shamt;
   logic [cse_pkg::QUO_W-1:0]   quo_neg;
   logic                        req_fire;

   assign req_ready      = (state_ff == cse_pkg::ST_IDLE);
   assign req_fire       = req_valid && req_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_similarity = sim_ff;
   assign rsp_zero_norm  = zflag_ff;
   assign rsp_too_long   = long_ff;

   always_comb begin
      if (phase_ff) begin
         mul_a = {1'b0, cse_pkg::norm_limb(norm1_ff, ia_ff)};
         mul_b = {1'b0, cse_pkg::norm_limb(norm2_ff, ib_ff)};
      end else begin
         case (ia_ff)
            cse_pkg::MAC_DOT: begin
               mul_a = cse_pkg::MULT_W'(a_ff);
               mul_b = cse_pkg::MULT_W'(b_ff);
            end
            cse_pkg::MAC_FIRST: begin
               mul_a = cse_pkg::MULT_W'(a_ff);
               mul_b = cse_pkg::MULT_W'(a_ff);
            end
            default: begin
               mul_a = cse_pkg::MULT_W'(b_ff);
               mul_b = cse_pkg::MULT_W'(b_ff);
            end
         endcase
      end
      mul_p = mul_a * mul_b;
   end

   always_comb begin
      if (state_ff == cse_pkg::ST_ROOT) begin
         sub_a = {rem_ff[cse_pkg::REM_W-3:0], work_ff[cse_pkg::WORK_W-1 -: 2]};
         sub_b = {root_ff, 2'b01};
      end else begin
         sub_a = {rem_ff[cse_pkg::REM_W-2:0], work_ff[cse_pkg::WORK_W-1]};
         sub_b = {(cse_pkg::REM_W-cse_pkg::ROOT_W)'(0), root_ff};
      end
      sub_d  = sub_a - sub_b;
      sub_ge = (sub_a >= sub_b);
   end

   assign dot_mag = dot_ff[cse_pkg::DOT_W-1] ? (~dot_ff + cse_pkg::DOT_W'(1)) : dot_ff;
   assign shamt   = {({1'b0, ia_ff} + {1'b0, ib_ff}), 4'b0000};
   assign partial = {(cse_pkg::WORK_W-32)'(0), prod_ff[31:0]} << shamt;
   assign quo_neg = ~quo_ff + cse_pkg::QUO_W'(1);

   always_comb begin
      state_in     = state_ff;
      dot_in       = dot_ff;
      norm1_in     = norm1_ff;
      norm2_in     = norm2_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      last_in      = last_ff;
      phase_in     = phase_ff;
      ia_in        = ia_ff;
      ib_in        = ib_ff;
      prod_in      = prod_ff;
      work_in      = work_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      quo_in       = quo_ff;
      big_in       = big_ff;
      neg_in       = neg_ff;
      zero_in      = zero_ff;
      iter_in      = iter_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      sim_in       = sim_ff;
      zflag_in     = zflag_ff;
      long_in      = long_ff;

      case (state_ff)
         cse_pkg::ST_IDLE: begin
            if (req_fire) begin
               a_in    = req_first_value;
               b_in    = req_second_value;
               last_in = req_last;
               if (count_ff == CNT_FULL) begin
                  // drop the pair, only remember it came
                  ovf_in   = 1'b1;
                  state_in = req_last ? cse_pkg::ST_NORM : cse_pkg::ST_IDLE;
               end else begin
                  count_in = count_ff + CNT_W'(1);
                  phase_in = 1'b0;
                  ia_in    = cse_pkg::MAC_DOT;
                  state_in = cse_pkg::ST_MUL;
               end
            end
         end
         cse_pkg::ST_MUL: begin
            prod_in  = mul_p;
            state_in = cse_pkg::ST_ADD;
         end
         cse_pkg::ST_ADD: begin
            if (phase_ff) begin
               work_in = work_ff + partial;
               if (ib_ff == cse_pkg::LIMB_LAST) begin
                  ib_in = 2'd0;
                  if (ia_ff == cse_pkg::LIMB_LAST) begin
                     rem_in   = '0;
                     root_in  = '0;
                     iter_in  = '0;
                     state_in = cse_pkg::ST_ROOT;
                  end else begin
                     ia_in    = ia_ff + 2'd1;
                     state_in = cse_pkg::ST_MUL;
                  end
               end else begin
                  ib_in    = ib_ff + 2'd1;
                  state_in = cse_pkg::ST_MUL;
               end
            end else begin
               case (ia_ff)
                  cse_pkg::MAC_DOT:
                     dot_in = dot_ff + {{(cse_pkg::DOT_W-cse_pkg::PROD_W){prod_ff[cse_pkg::PROD_W-1]}},
                                        prod_ff};
                  cse_pkg::MAC_FIRST:
                     norm1_in = norm1_ff + {(cse_pkg::NORM_W-cse_pkg::PROD_W)'(0), prod_ff};
                  default:
                     norm2_in = norm2_ff + {(cse_pkg::NORM_W-cse_pkg::PROD_W)'(0), prod_ff};
               endcase
               if (ia_ff == cse_pkg::MAC_SECOND) begin
                  state_in = last_ff ? cse_pkg::ST_NORM : cse_pkg::ST_IDLE;
               end else begin
                  ia_in    = ia_ff + 2'd1;
                  state_in = cse_pkg::ST_MUL;
               end
            end
         end
         cse_pkg::ST_NORM: begin
            if (norm1_ff == '0 || norm2_ff == '0) begin
               zero_in  = 1'b1;
               state_in = cse_pkg::ST_DONE;
            end else begin
               zero_in  = 1'b0;
               work_in  = '0;
               phase_in = 1'b1;
               ia_in    = 2'd0;
               ib_in    = 2'd0;
               state_in = cse_pkg::ST_MUL;
            end
         end
         cse_pkg::ST_ROOT: begin
            rem_in  = sub_ge ? sub_d : sub_a;
            root_in = {root_ff[cse_pkg::ROOT_W-2:0], sub_ge};
            work_in = {work_ff[cse_pkg::WORK_W-3:0], 2'b00};
            iter_in = iter_ff + cse_pkg::ITER_W'(1);
            if (iter_ff == cse_pkg::ROOT_LAST) begin
               // load the dividend |dot| << 15 at the top of the shift register
               work_in  = {dot_mag, 15'd0, cse_pkg::DIV_PAD'(0)};
               rem_in   = '0;
               iter_in  = '0;
               quo_in   = '0;
               big_in   = 1'b0;
               neg_in   = dot_ff[cse_pkg::DOT_W-1];
               state_in = cse_pkg::ST_DIV;
            end
         end
         cse_pkg::ST_DIV: begin
            rem_in  = sub_ge ? sub_d : sub_a;
            quo_in  = {quo_ff[cse_pkg::QUO_W-2:0], sub_ge};
            big_in  = big_ff | quo_ff[cse_pkg::QUO_W-1];
            work_in = {work_ff[cse_pkg::WORK_W-2:0], 1'b0};
            iter_in = iter_ff + cse_pkg::ITER_W'(1);
            if (iter_ff == cse_pkg::DIV_LAST) begin
               state_in = cse_pkg::ST_DONE;
            end
         end
         cse_pkg::ST_DONE: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               zflag_in     = zero_ff;
               long_in      = ovf_ff;
               if (zero_ff) begin
                  sim_in = '0;
               end else if (neg_ff) begin
                  sim_in = (big_ff || quo_ff > cse_pkg::QUO_NEG_MAX) ? cse_pkg::SIM_MIN
                                                                     : quo_neg[cse_pkg::SIM_W-1:0];
               end else begin
                  sim_in = (big_ff || quo_ff > cse_pkg::QUO_POS_MAX) ? cse_pkg::SIM_MAX
                                                                     : quo_ff[cse_pkg::SIM_W-1:0];
               end
               dot_in   = '0;
               norm1_in = '0;
               norm2_in = '0;
               count_in = '0;
               ovf_in   = 1'b0;
               state_in = cse_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cse_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cse_pkg::ST_IDLE;
         dot_ff       <= '0;
         norm1_ff     <= '0;
         norm2_ff     <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         phase_ff     <= 1'b0;
         ia_ff        <= '0;
         ib_ff        <= '0;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dot_ff       <= dot_in;
         norm1_ff     <= norm1_in;
         norm2_ff     <= norm2_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         phase_ff     <= phase_in;
         ia_ff        <= ia_in;
         ib_ff        <= ib_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff     <= a_in;
      b_ff     <= b_in;
      last_ff  <= last_in;
      prod_ff  <= prod_in;
      work_ff  <= work_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      quo_ff   <= quo_in;
      big_ff   <= big_in;
      neg_ff   <= neg_in;
      zero_ff  <= zero_in;
      sim_ff   <= sim_in;
      zflag_ff <= zflag_in;
      long_ff  <= long_in;
   end

endmodule

// ===== rtl/core/cse_checker.sv =====
// ----------------------------------------------------------------------------
// Cosine similarity engine port checker
// Watches the engine ports for result and handshake consistency over time.
// ----------------------------------------------------------------------------
`include "cosine_similarity_engine_macros.svh"

module cse_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          req_last,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [cse_pkg::SIM_W-1:0]     rsp_similarity,
   input logic                          rsp_zero_norm,
   input logic                          rsp_too_long
);

   `CSE_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_similarity) && $stable(rsp_zero_norm) && $stable(rsp_too_long), "result word changed while stalled")

   `CSE_ASSERT(a_zero_sim, rsp_valid && rsp_zero_norm |-> rsp_similarity == '0, "zero norm result with nonzero similarity")

   `CSE_ASSERT(a_no_early_rsp, req_valid && req_ready && !req_last |=> !$rose(rsp_valid), "result raised after a word without last")

   `CSE_ASSERT_ALWAYS(a_reset_clear, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind cosine_similarity_engine cse_checker u_cse_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .req_last       (req_last),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_similarity (rsp_similarity),
   .rsp_zero_norm  (rsp_zero_norm),
   .rsp_too_long   (rsp_too_long)
);

// ===== tb/cosine_similarity_engine_check.sv =====
// ----------------------------------------------------------------------------
// Cosine similarity engine checker
// Watches both channels of the engine. It sums each accepted element pair up to
// full length, works out the similarity word at each last pair, and compares it
// field by field with the words that come back, oldest first.
// ----------------------------------------------------------------------------
module cosine_similarity_engine_check #(
   parameter int MAX_DIM = cse_pkg::MAX_DIM_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic signed [cse_pkg::VAL_W-1:0]  req_first_value,
   input  logic signed [cse_pkg::VAL_W-1:0]  req_second_value,
   input  logic                              req_last,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic signed [cse_pkg::SIM_W-1:0]  rsp_similarity,
   input  logic                              rsp_zero_norm,
   input  logic                              rsp_too_long,
   output int                                mismatch_count,
   output int                                pending_count,
   output int                                checked_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC_SHIFT = cse_pkg::SIM_W - 1;
   localparam int REPORT_CAP = 40;

   typedef struct packed {
      logic [cse_pkg::SIM_W-1:0] similarity;
      logic                      zero_norm;
      logic                      too_long;
   } score_type;

   score_type                  expected_scores[$];
   logic [cse_pkg::DOT_W-1:0]  dot_acc;
   logic [cse_pkg::NORM_W-1:0] first_norm_acc;
   logic [cse_pkg::NORM_W-1:0] second_norm_acc;
   int                         pairs_taken;
   logic                       overflowed;
   int                         mismatches;
   int                         checked;

   function automatic score_type predict_similarity(input logic [cse_pkg::DOT_W-1:0] dot,
                                                    input logic [cse_pkg::NORM_W-1:0] norm_a,
                                                    input logic [cse_pkg::NORM_W-1:0] norm_b,
                                                    input logic overflow);
      score_type                            s;
      logic [2*cse_pkg::NORM_W-1:0]         norm_prod;
      logic [cse_pkg::ROOT_W-1:0]           root;
      logic [cse_pkg::ROOT_W-1:0]           cand;
      logic [2*cse_pkg::ROOT_W-1:0]         cand_sq;
      logic [cse_pkg::DOT_W-1:0]            mag;
      logic [cse_pkg::DOT_W+FRAC_SHIFT-1:0] quo;
      logic                                 neg;
      s.similarity = '0;
      s.zero_norm  = 1'b0;
      s.too_long   = overflow;
      if (norm_a == '0 || norm_b == '0) begin
         s.zero_norm = 1'b1;
      end else begin
         norm_prod = {{cse_pkg::NORM_W{1'b0}}, norm_a} * {{cse_pkg::NORM_W{1'b0}}, norm_b};
         // floor square root, one bit per pass from the top
         root = '0;
         for (int b = cse_pkg::ROOT_W - 1; b >= 0; b--) begin
            cand    = root | (cse_pkg::ROOT_W'(1) << b);
            cand_sq = {{cse_pkg::ROOT_W{1'b0}}, cand} * {{cse_pkg::ROOT_W{1'b0}}, cand};
            if (cand_sq <= (2*cse_pkg::ROOT_W)'(norm_prod))
               root = cand;
         end
         if (root == '0)
            root = cse_pkg::ROOT_W'(1);
         neg = dot[cse_pkg::DOT_W-1];
         mag = neg ? (~dot + 1'b1) : dot;
         quo = {mag, {FRAC_SHIFT{1'b0}}} / {{FRAC_SHIFT{1'b0}}, root};
         if (neg) begin
            if (quo > cse_pkg::QUO_NEG_MAX)
               quo = cse_pkg::QUO_NEG_MAX;
            s.similarity = cse_pkg::SIM_W'((cse_pkg::DOT_W+FRAC_SHIFT)'(0) - quo);
         end else begin
            if (quo > cse_pkg::QUO_POS_MAX)
               quo = cse_pkg::QUO_POS_MAX;
            s.similarity = quo[cse_pkg::SIM_W-1:0];
         end
      end
      return s;
   endfunction

   task automatic check_field(input string name,
                              input logic signed [cse_pkg::SIM_W-1:0] want,
                              input logic signed [cse_pkg::SIM_W-1:0] got);
      if (want !== got) begin
         if (mismatches < REPORT_CAP)
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      score_type                          want;
      logic signed [2*cse_pkg::VAL_W-1:0] prod_ab;
      logic signed [2*cse_pkg::VAL_W-1:0] prod_aa;
      logic signed [2*cse_pkg::VAL_W-1:0] prod_bb;
      if (reset) begin
         dot_acc         = '0;
         first_norm_acc  = '0;
         second_norm_acc = '0;
         pairs_taken     = 0;
         overflowed      = 1'b0;
         mismatches      = 0;
         checked         = 0;
         expected_scores.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_scores.size() == 0) begin
               if (mismatches < REPORT_CAP)
                  $display("%0t: result word with none expected, actual %0d/%0b/%0b",
                           $time, rsp_similarity, rsp_zero_norm, rsp_too_long);
               mismatches++;
            end else begin
               want = expected_scores.pop_front();
               check_field("similarity", want.similarity, rsp_similarity);
               check_field("zero_norm", cse_pkg::SIM_W'(want.zero_norm),
                           cse_pkg::SIM_W'(rsp_zero_norm));
               check_field("too_long", cse_pkg::SIM_W'(want.too_long),
                           cse_pkg::SIM_W'(rsp_too_long));
               checked++;
            end
         end
         if (req_valid && req_ready) begin
            if (pairs_taken < MAX_DIM) begin
               prod_ab         = req_first_value * req_second_value;
               prod_aa         = req_first_value * req_first_value;
               prod_bb         = req_second_value * req_second_value;
               dot_acc         = dot_acc + cse_pkg::DOT_W'(prod_ab);
               first_norm_acc  = first_norm_acc + cse_pkg::NORM_W'(prod_aa);
               second_norm_acc = second_norm_acc + cse_pkg::NORM_W'(prod_bb);
               pairs_taken++;
            end else begin
               // drop the pair, remember the vector ran long
               overflowed = 1'b1;
            end
            if (req_last) begin
               // append at the tail, oldest stays in front
               expected_scores.insert(expected_scores.size(),
                                      predict_similarity(dot_acc, first_norm_acc,
                                                         second_norm_acc, overflowed));
               dot_acc         = '0;
               first_norm_acc  = '0;
               second_norm_acc = '0;
               pairs_taken     = 0;
               overflowed      = 1'b0;
            end
         end
      end
      mismatch_count <= mismatches;
      pending_count  <= expected_scores.size();
      checked_count  <= checked;
   end

endmodule

// ===== tb/cosine_similarity_engine_test.sv =====
// ----------------------------------------------------------------------------
// Cosine similarity engine testbench
// Sends directed and random vector pairs, one vector past full length, and
// random vectors under four idling modes on both channels. The attached
// checker predicts and compares every similarity word.
// ----------------------------------------------------------------------------
module cosine_similarity_engine_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_HALF   = 5;
   localparam int RESET_CYCLES = 12;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 250;
   localparam int RANDOM_PAIRS = 550;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;
   typedef enum int {PICK_FULL, PICK_EDGE, PICK_SMALL} pick_style_type;
   typedef enum int {VEC_INDEP, VEC_SAME, VEC_NEGATED, VEC_NEAR, VEC_FIRST_ZERO,
                     VEC_SECOND_ZERO} vector_kind_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   logic signed [cse_pkg::VAL_W-1:0]  req_first_value = '0;
   logic signed [cse_pkg::VAL_W-1:0]  req_second_value = '0;
   logic                              req_last = 1'b0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic signed [cse_pkg::SIM_W-1:0]  rsp_similarity;
   logic                              rsp_zero_norm;
   logic                              rsp_too_long;

   int mismatch_count;
   int pending_count;
   int checked_count;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int pairs_sent = 0;
   int vectors_sent = 0;

   cosine_similarity_engine #(
      .MAX_DIM(cse_pkg::MAX_DIM_DEF)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_first_value (req_first_value),
      .req_second_value(req_second_value),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_similarity  (rsp_similarity),
      .rsp_zero_norm   (rsp_zero_norm),
      .rsp_too_long    (rsp_too_long)
   );

   cosine_similarity_engine_check #(
      .MAX_DIM(cse_pkg::MAX_DIM_DEF)
   ) i_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_first_value (req_first_value),
      .req_second_value(req_second_value),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_similarity  (rsp_similarity),
      .rsp_zero_norm   (rsp_zero_norm),
      .rsp_too_long    (rsp_too_long),
      .mismatch_count  (mismatch_count),
      .pending_count   (pending_count),
      .checked_count   (checked_count)
   );

   always #CLOCK_HALF clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      rsp_ready   <= ($urandom_range(99) >= recv_stall_pct);
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic set_idle(input idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         IDLE_SENDER: begin
            send_idle_pct = 75;
            recv_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct = 0;
            recv_stall_pct = 75;
         end
         default: begin
            send_idle_pct = 15;
            recv_stall_pct = 15;
         end
      endcase
   endtask

   // Send one element pair; valid stays up across back-to-back words.
   task automatic send_pair(input logic [cse_pkg::VAL_W-1:0] a,
                            input logic [cse_pkg::VAL_W-1:0] b,
                            input logic is_last);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_first_value  <= a;
      req_second_value <= b;
      req_last         <= is_last;
      do
         @(posedge clock);
      while (!req_ready);
      pairs_sent++;
      if (is_last)
         vectors_sent++;
   endtask

   function automatic logic [cse_pkg::VAL_W-1:0] pick_element(input pick_style_type style);
      logic [cse_pkg::VAL_W-1:0] v;
      case (style)
         PICK_EDGE: begin
            case ($urandom_range(4))
               0:       v = 16'h8000;
               1:       v = 16'h7FFF;
               2:       v = 16'h0000;
               3:       v = 16'hFFFF;
               default: v = 16'h0001;
            endcase
         end
         PICK_SMALL: v = cse_pkg::VAL_W'($urandom_range(128)) - 16'd64;
         default:    v = cse_pkg::VAL_W'($urandom);
      endcase
      return v;
   endfunction

   task automatic send_random_vector(input int len);
      vector_kind_type           kind;
      pick_style_type            style;
      logic [cse_pkg::VAL_W-1:0] a;
      logic [cse_pkg::VAL_W-1:0] b;
      kind  = vector_kind_type'($urandom_range(VEC_SECOND_ZERO));
      style = pick_style_type'($urandom_range(PICK_SMALL));
      for (int i = 0; i < len; i++) begin
         a = pick_element(style);
         case (kind)
            VEC_SAME:        b = a;
            VEC_NEGATED:     b = -a;
            VEC_NEAR:        b = a + pick_element(PICK_SMALL);
            VEC_FIRST_ZERO: begin
               b = a;
               a = '0;
            end
            VEC_SECOND_ZERO: b = '0;
            default:         b = pick_element(pick_style_type'($urandom_range(PICK_SMALL)));
         endcase
         // mostly clean vectors, now and then a stray element of any kind
         if ($urandom_range(19) == 0)
            b = pick_element(PICK_FULL);
         send_pair(a, b, i == len - 1);
      end
   endtask

   initial begin
      int goal;
      int len;
      set_idle(IDLE_NONE);
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // single pairs at the corners: saturation both ways, zero norms
      send_pair(16'h7FFF, 16'h7FFF, 1'b1);
      send_pair(16'h8000, 16'h8000, 1'b1);
      send_pair(16'h7FFF, 16'h8000, 1'b1);
      send_pair(16'h8000, 16'h7FFF, 1'b1);
      send_pair(16'h0000, 16'h0000, 1'b1);
      send_pair(16'h1000, 16'h0000, 1'b1);
      send_pair(16'h0000, 16'h1000, 1'b1);
      // orthogonal
      send_pair(16'h1000, 16'h0000, 1'b0);
      send_pair(16'h0000, 16'h1000, 1'b1);
      // mixed signs
      send_pair(16'h1000, 16'h2000, 1'b0);
      send_pair(16'hF000, 16'h0800, 1'b0);
      send_pair(16'h0001, 16'hFFFF, 1'b1);
      send_pair(16'h0001, 16'h0001, 1'b0);
      send_pair(16'hFFFF, 16'hFFFF, 1'b1);

      // fill to full length, then run past it
      len = cse_pkg::MAX_DIM_DEF + $urandom_range(1, 6);
      for (int i = 0; i < len; i++)
         send_pair(pick_element(PICK_FULL), pick_element(PICK_FULL), i == len - 1);
      send_random_vector(3);

      for (int m = IDLE_NONE; m <= IDLE_BOTH; m++) begin
         set_idle(idle_mode_type'(m));
         goal = pairs_sent + RANDOM_PAIRS / 4;
         while (pairs_sent < goal) begin
            if ($urandom_range(7) == 0)
               len = $urandom_range(9, 48);
            else
               len = $urandom_range(1, 8);
            send_random_vector(len);
         end
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending_count != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d element pairs in %0d vectors, one past full length included,",
               pairs_sent, vectors_sent);
      $display("under four idling modes; %0d similarity words compared.", checked_count);
      if (mismatch_count == 0 && pending_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/cse_pkg.sv
rtl/core/cosine_similarity_engine.sv
rtl/core/cse_checker.sv
tb/cosine_similarity_engine_check.sv
tb/cosine_similarity_engine_test.sv
